### rtl/core/trs_pkg.sv
// shared types, codes and helpers for the teaching risc step unit
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    localparam int unsigned MEM_DEPTH_DEF = 512;
    localparam int unsigned NUM_REGS      = 16;
    localparam int unsigned XLEN          = 32;
    localparam int unsigned RIDX_W        = 4;
    localparam int unsigned ADDR_IN_W     = 9;
    localparam int unsigned PC_OUT_W      = 9;

    // item kinds
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_EXEC  = 2'd1;
    localparam logic [1:0] FUNC_MEMRD = 2'd2;
    localparam logic [1:0] FUNC_REGRD = 2'd3;

    // opcodes
    localparam logic [7:0] OP_ADD  = 8'd0;
    localparam logic [7:0] OP_SUB  = 8'd1;
    localparam logic [7:0] OP_AND  = 8'd2;
    localparam logic [7:0] OP_OR   = 8'd3;
    localparam logic [7:0] OP_SLL  = 8'd4;
    localparam logic [7:0] OP_SRA  = 8'd5;
    localparam logic [7:0] OP_SRL  = 8'd6;
    localparam logic [7:0] OP_BEQ  = 8'd7;
    localparam logic [7:0] OP_BNE  = 8'd8;
    localparam logic [7:0] OP_BLT  = 8'd9;
    localparam logic [7:0] OP_BGT  = 8'd10;
    localparam logic [7:0] OP_BLE  = 8'd11;
    localparam logic [7:0] OP_BGE  = 8'd12;
    localparam logic [7:0] OP_JAL  = 8'd13;
    localparam logic [7:0] OP_LW   = 8'd14;
    localparam logic [7:0] OP_SW   = 8'd15;
    localparam logic [7:0] OP_HALT = 8'd19;

    // fixed register numbers
    localparam logic [RIDX_W-1:0] REG_ZERO = 4'd0;
    localparam logic [RIDX_W-1:0] REG_IMM  = 4'd1;
    localparam logic [RIDX_W-1:0] REG_LINK = 4'd15;

    typedef struct packed {
        logic [1:0]           func;
        logic [ADDR_IN_W-1:0] mem_address;
        logic [XLEN-1:0]      write_word;
        logic [RIDX_W-1:0]    reg_index;
    } cmd_t;

    typedef struct packed {
        logic [PC_OUT_W-1:0] fetched_pc;
        logic [XLEN-1:0]     fetched_instruction;
        logic [XLEN-1:0]     read_word;
        logic                halted;
        logic [XLEN-1:0]     cycle_count;
    } rsp_t;

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            take;
        logic            addr_ok;
        logic [XLEN-1:0] sum;
    } alu_t;

    typedef struct packed {
        logic              re0;
        logic [RIDX_W-1:0] ra0;
        logic              re1;
        logic [RIDX_W-1:0] ra1;
        logic              we;
        logic [RIDX_W-1:0] wa;
        logic [XLEN-1:0]   wd;
    } rf_req_t;

    function automatic logic [XLEN-1:0] sext12(input logic [XLEN-1:0] w);
        return {{(XLEN-12){w[11]}}, w[11:0]};
    endfunction

endpackage

`default_nettype wire

### rtl/core/trs_cmd_if.sv
// command channel carrying one item per transaction
`timescale 1ns / 1ps
`default_nettype none

interface trs_cmd_if import trs_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/trs_rsp_if.sv
// response channel carrying one result per transaction
`timescale 1ns / 1ps
`default_nettype none

interface trs_rsp_if import trs_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/trs_word_mem.sv
// unified word memory, one write and one registered read port, cleared after reset
`timescale 1ns / 1ps
`default_nettype none

module trs_word_mem import trs_pkg::*; #(
    parameter int unsigned DEPTH = MEM_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  logic [XLEN-1:0] wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output logic [XLEN-1:0] rdata,
    output logic            busy
);

    logic [XLEN-1:0] word_reg [DEPTH];
    logic [XLEN-1:0] rdata_reg;
    logic [AW-1:0]   clr_idx_reg, clr_idx_next;
    logic            clearing_reg, clearing_next;

    always_comb
    begin
        clr_idx_next  = clr_idx_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_idx_reg  <= clr_idx_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            word_reg[clr_idx_reg] <= '0;
        end
        else if (we)
        begin
            word_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= word_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

`default_nettype wire

### rtl/core/trs_reg_file.sv
// 16 x 32 register file, two registered read ports, one write port, per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none

module trs_reg_file import trs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  rf_req_t         req,
    output logic [XLEN-1:0] rdata0,
    output logic [XLEN-1:0] rdata1
);

    logic [XLEN-1:0]     entry_reg [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [XLEN-1:0]     q0_reg, q1_reg;
    logic                v0_reg, v1_reg;

    // r0 is never written, so its valid bit stays low and it reads zero
    always_ff @(posedge clk)
    begin
        if (req.we && req.wa != REG_ZERO)
        begin
            entry_reg[req.wa] <= req.wd;
        end
        if (req.re0)
        begin
            q0_reg <= entry_reg[req.ra0];
        end
        if (req.re1)
        begin
            q1_reg <= entry_reg[req.ra1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
        end
        else
        begin
            if (req.we && req.wa != REG_ZERO)
            begin
                valid_reg[req.wa] <= 1'b1;
            end
            if (req.re0)
            begin
                v0_reg <= valid_reg[req.ra0];
            end
            if (req.re1)
            begin
                v1_reg <= valid_reg[req.ra1];
            end
        end
    end

    assign rdata0 = v0_reg ? q0_reg : '0;
    assign rdata1 = v1_reg ? q1_reg : '0;

endmodule

`default_nettype wire

### rtl/core/trs_alu.sv
// arithmetic, shifts, branch compares and load/store address
`timescale 1ns / 1ps
`default_nettype none

module trs_alu import trs_pkg::*; (
    input  logic [7:0]      op,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    output alu_t            res
);

    logic [4:0] shamt;
    logic       a_lt_b;
    logic       b_lt_a;

    assign shamt  = b[4:0];
    assign a_lt_b = $signed(a) < $signed(b);
    assign b_lt_a = $signed(b) < $signed(a);

    always_comb
    begin
        res.value   = '0;
        res.take    = 1'b0;
        res.sum     = a + b;
        res.addr_ok = ~res.sum[XLEN-1];
        case (op)
            OP_ADD: res.value = a + b;
            OP_SUB: res.value = a - b;
            OP_AND: res.value = a & b;
            OP_OR:  res.value = a | b;
            OP_SLL: res.value = a << shamt;
            OP_SRA: res.value = XLEN'($signed(a) >>> shamt);
            OP_SRL: res.value = a >> shamt;
            OP_BEQ: res.take  = (a == b);
            OP_BNE: res.take  = (a != b);
            OP_BLT: res.take  = a_lt_b;
            OP_BGT: res.take  = b_lt_a;
            OP_BLE: res.take  = ~b_lt_a;
            OP_BGE: res.take  = ~a_lt_b;
            default: res.take = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/teaching_risc_instruction_step_unit.sv
// top level: item sequencer around the word memory and register file
//
//  channel | role   | carries
//  --------+--------+----------------------------------------------------
//  cmd     | sink   | func, mem_address, write_word, reg_index
//  rsp     | source | fetched_pc, fetched_instruction, read_word, halted,
//          |        | cycle_count
//
// load, read and halted-execute items: one per cycle unless rsp stalls; result via pending reg, then rsp reg
// execute: EX1-EX2 for alu, halt and unused opcodes, EX1-EX3 for branch, jal, lw, sw;
//   set by the single memory read port (fetch, then data) and the register reads
// after reset the word memory is swept to zero, with cmd.ready low
// MEM_DEPTH must be a power of two, which the block does not check; a full rsp register stalls only the last step
`timescale 1ns / 1ps
`default_nettype none

module teaching_risc_instruction_step_unit import trs_pkg::*; #(
    parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    trs_cmd_if.sink    cmd,
    trs_rsp_if.source  rsp
);

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    typedef enum logic [3:0] {
        ST_RUN = 4'b0001,
        ST_EX1 = 4'b0010,
        ST_EX2 = 4'b0100,
        ST_EX3 = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   pc_reg, pc_next;
    logic [AW-1:0]   fpc_reg, fpc_next;
    logic            halt_reg, halt_next;
    logic [XLEN-1:0] count_reg, count_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [1:0]      pend_func_reg, pend_func_next;
    logic [XLEN-1:0] inst_reg, inst_next;
    alu_t            alu_q_reg, alu_q_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_data_reg, out_data_next;

    logic            mem_we, mem_re, mem_busy;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [XLEN-1:0] mem_wdata, mem_rdata;

    rf_req_t         rf_req;
    logic [XLEN-1:0] rf_rdata0, rf_rdata1;

    logic [7:0]        op;
    logic [RIDX_W-1:0] rd, rs, rt;
    logic [XLEN-1:0]   imm, opa, opb, rdv, pc_ext;
    alu_t              alu_res;
    logic [AW+8:0]     cmd_addr_ext, fpc_ext;
    logic [AW+11:0]    tgt_ext;
    logic [AW-1:0]     cmd_addr, tgt;
    logic              accept, slot_free;

    trs_word_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    trs_reg_file u_rf (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (rf_req),
        .rdata0 (rf_rdata0),
        .rdata1 (rf_rdata1)
    );

    trs_alu u_alu (
        .op  (op),
        .a   (opa),
        .b   (opb),
        .res (alu_res)
    );

    assign op  = inst_reg[31:24];
    assign rd  = inst_reg[23:20];
    assign rs  = inst_reg[19:16];
    assign rt  = inst_reg[15:12];
    assign imm = sext12(inst_reg);

    // r1 is written in the same cycle the operands are read, so bypass it
    assign opa = (rs == REG_IMM) ? imm : rf_rdata0;
    assign opb = (rt == REG_IMM) ? imm : rf_rdata1;

    // pc_reg already holds pc+1 here; jal through r15 lands on it
    assign pc_ext = XLEN'(pc_reg);
    assign rdv    = (op == OP_JAL && rd == REG_LINK) ? pc_ext : rf_rdata0;

    assign tgt_ext      = (AW+12)'(rdv[11:0]);
    assign tgt          = tgt_ext[AW-1:0];
    assign cmd_addr_ext = (AW+9)'(cmd.data.mem_address);
    assign cmd_addr     = cmd_addr_ext[AW-1:0];
    assign fpc_ext      = (AW+9)'(fpc_reg);

    assign slot_free = ~out_valid_reg | rsp.ready;
    assign cmd.ready = (state_reg == ST_RUN) & ~mem_busy & (~pend_valid_reg | slot_free);
    assign accept    = cmd.valid & cmd.ready;

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        fpc_next        = fpc_reg;
        halt_next       = halt_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_func_next  = pend_func_reg;
        inst_next       = inst_reg;
        alu_q_next      = alu_q_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = cmd_addr;
        mem_wdata       = cmd.data.write_word;
        mem_re          = 1'b0;
        mem_raddr       = cmd_addr;
        rf_req          = '0;

        // finish a load, read or halted-execute transaction
        if (pend_valid_reg && slot_free)
        begin
            pend_valid_next                   = 1'b0;
            out_valid_next                    = 1'b1;
            out_data_next.fetched_pc          = '0;
            out_data_next.fetched_instruction = '0;
            out_data_next.halted              = halt_reg;
            out_data_next.cycle_count         = count_reg;
            case (pend_func_reg)
                FUNC_MEMRD: out_data_next.read_word = mem_rdata;
                FUNC_REGRD: out_data_next.read_word = rf_rdata0;
                default:    out_data_next.read_word = '0;
            endcase
        end

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (cmd.data.func == FUNC_EXEC && !halt_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = pc_reg;
                        fpc_next   = pc_reg;
                        state_next = ST_EX1;
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_func_next  = cmd.data.func;
                        case (cmd.data.func)
                            FUNC_LOAD:  mem_we = 1'b1;
                            FUNC_MEMRD: mem_re = 1'b1;
                            FUNC_REGRD:
                            begin
                                rf_req.re0 = 1'b1;
                                rf_req.ra0 = cmd.data.reg_index;
                            end
                            default: ;
                        endcase
                    end
                end
            end

            ST_EX1:
            begin
                inst_next  = mem_rdata;
                pc_next    = pc_reg + 1'b1;
                rf_req.we  = 1'b1;
                rf_req.wa  = REG_IMM;
                rf_req.wd  = sext12(mem_rdata);
                rf_req.re0 = 1'b1;
                rf_req.ra0 = mem_rdata[19:16];
                rf_req.re1 = 1'b1;
                rf_req.ra1 = mem_rdata[15:12];
                state_next = ST_EX2;
            end

            ST_EX2:
            begin
                if (op inside {[OP_BEQ:OP_SW]})
                begin
                    alu_q_next = alu_res;
                    rf_req.re0 = 1'b1;
                    rf_req.ra0 = rd;
                    if (op == OP_LW && alu_res.addr_ok)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = alu_res.sum[AW-1:0];
                    end
                    state_next = ST_EX3;
                end
                else if (slot_free)
                begin
                    if (op inside {[OP_ADD:OP_SRL]})
                    begin
                        rf_req.we = 1'b1;
                        rf_req.wa = rd;
                        rf_req.wd = alu_res.value;
                    end
                    if (op == OP_HALT)
                    begin
                        halt_next = 1'b1;
                    end
                    count_next                        = count_reg + 1'b1;
                    out_valid_next                    = 1'b1;
                    out_data_next.fetched_pc          = fpc_ext[PC_OUT_W-1:0];
                    out_data_next.fetched_instruction = inst_reg;
                    out_data_next.read_word           = '0;
                    out_data_next.halted              = halt_reg | (op == OP_HALT);
                    out_data_next.cycle_count         = count_reg + 1'b1;
                    state_next                        = ST_RUN;
                end
            end

            ST_EX3:
            begin
                if (slot_free)
                begin
                    if (op inside {[OP_BEQ:OP_BGE]})
                    begin
                        if (alu_q_reg.take)
                        begin
                            pc_next = tgt;
                        end
                    end
                    else if (op == OP_JAL)
                    begin
                        rf_req.we = 1'b1;
                        rf_req.wa = REG_LINK;
                        rf_req.wd = pc_ext;
                        pc_next   = tgt;
                    end
                    else if (op == OP_LW)
                    begin
                        rf_req.we = alu_q_reg.addr_ok;
                        rf_req.wa = rd;
                        rf_req.wd = mem_rdata;
                    end
                    else
                    begin
                        mem_we    = alu_q_reg.addr_ok;
                        mem_waddr = alu_q_reg.sum[AW-1:0];
                        mem_wdata = rdv;
                    end
                    count_next                        = count_reg + 1'b1;
                    out_valid_next                    = 1'b1;
                    out_data_next.fetched_pc          = fpc_ext[PC_OUT_W-1:0];
                    out_data_next.fetched_instruction = inst_reg;
                    out_data_next.read_word           = '0;
                    out_data_next.halted              = halt_reg;
                    out_data_next.cycle_count         = count_reg + 1'b1;
                    state_next                        = ST_RUN;
                end
            end

            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            halt_reg       <= halt_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fpc_reg       <= fpc_next;
        pend_func_reg <= pend_func_next;
        inst_reg      <= inst_next;
        alu_q_reg     <= alu_q_next;
        out_data_reg  <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // a pending non-execute transaction never overlaps an instruction in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> state_reg == ST_RUN)
        else $error("pending transaction outside run state");

    // register writes come only from instruction steps
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> !rf_req.we)
        else $error("register write while idle");

    // memory writes only from load items or a store step
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_RUN || state_reg == ST_EX3))
        else $error("memory write from wrong step");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EX1 |=> state_reg == ST_EX2)
        else $error("fetch step not followed by operand step");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == ST_EX2 || state_reg == ST_EX3) && out_valid_reg)
        else $error("instruction count moved without a finished instruction");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(halt_reg))
        else $error("halt flag cleared");

endmodule

`default_nettype wire
